// ===== rtl/hgc_pkg.sv =====
// Package for the hash-grid corner request generator.
// Shared constants and the controller/datapath command and status types.
// No dependencies.
package hgc_pkg;

   // Spatial-hash primes for the y and z axes
   localparam logic [31:0] PRIME_Y = 32'd2654435761;
   localparam logic [31:0] PRIME_Z = 32'd805459861;

   // Grid resolution register
   localparam int          RES_BITS  = 13;
   localparam logic [12:0] RES_RESET = 13'd16;

   // Corner numbering: x offset in bit 2, y in bit 1, z in bit 0
   localparam int         CORNER_BITS = 3;
   localparam logic [2:0] LAST_CORNER = 3'd7;

   // Controller to datapath commands
   typedef struct packed {
      logic                   load_point;   // latch an accepted point
      logic                   scale;        // scale coordinates, split cell/fraction
      logic                   prep;         // per-axis weights and hash products
      logic                   load_corner;  // load one corner into the output register
      logic                   last_corner;  // the corner being loaded is the final one
      logic [CORNER_BITS-1:0] corner;       // corner being loaded
   } hgc_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;  // output register empty or being taken this cycle
   } hgc_status_type;

endpackage

// ===== rtl/hgc_ctrl.sv =====
// Sequencer for the hash-grid corner request generator.
// Walks each point through scale, prepare and eight corner loads.
// Depends on hgc_pkg.
module hgc_ctrl
   import hgc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  hgc_status_type status,
   output hgc_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCALE = 2'd1;
   localparam logic [1:0] ST_PREP  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CORNER_BITS-1:0] corner_ff, corner_in;
   logic                   emit_go;

   assign req_ready = (state_ff == ST_IDLE);
   assign emit_go   = (state_ff == ST_EMIT) && status.out_free;

   // Commands to the datapath
   always_comb begin
      cmd.load_point  = req_valid && req_ready;
      cmd.scale       = (state_ff == ST_SCALE);
      cmd.prep        = (state_ff == ST_PREP);
      cmd.load_corner = emit_go;
      cmd.last_corner = (corner_ff == LAST_CORNER);
      cmd.corner      = corner_ff;
   end

   // Next state
   always_comb begin
      state_in  = state_ff;
      corner_in = corner_ff;
      unique case (state_ff)
         ST_IDLE: begin
            corner_in = '0;
            if (req_valid) state_in = ST_SCALE;
         end
         ST_SCALE: state_in = ST_PREP;
         ST_PREP:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_go) begin
               corner_in = corner_ff + CORNER_BITS'(1);
               if (corner_ff == LAST_CORNER) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         corner_ff <= '0;
      end else begin
         state_ff  <= state_in;
         corner_ff <= corner_in;
      end
   end

endmodule

// ===== rtl/hgc_datapath.sv =====
// Datapath of the hash-grid corner request generator: resolution register,
// coordinate scaling, weight and hash products, output register, slot counter.
// Depends on hgc_pkg.
module hgc_datapath
   import hgc_pkg::*;
#(
   parameter int TABLE_ADDR_BITS = 19,
   parameter int COORD_FRAC_BITS = 16,
   parameter int DEST_BITS       = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hgc_cmd_type                cmd,
   output hgc_status_type             status,
   input  logic                       csr_wr_en,
   input  logic [RES_BITS-1:0]        csr_wr_data,
   input  logic [COORD_FRAC_BITS-1:0] req_coord_x,
   input  logic [COORD_FRAC_BITS-1:0] req_coord_y,
   input  logic [COORD_FRAC_BITS-1:0] req_coord_z,
   input  logic [15:0]                req_ray_index,
   input  logic [7:0]                 req_batch_index,
   input  logic [7:0]                 req_point_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [15:0]                rsp_ray_tag,
   output logic [7:0]                 rsp_batch_tag,
   output logic [7:0]                 rsp_point_tag,
   output logic [CORNER_BITS-1:0]     rsp_corner_number,
   output logic [TABLE_ADDR_BITS-1:0] rsp_table_address,
   output logic [COORD_FRAC_BITS:0]   rsp_corner_weight,
   output logic [DEST_BITS-1:0]       rsp_dest_slot,
   output logic                       rsp_last_corner
);

   localparam int F        = COORD_FRAC_BITS;
   localparam int A        = TABLE_ADDR_BITS;
   localparam int WEIGHT_W = F + 1;
   localparam int SCALE_W  = F + RES_BITS;
   localparam int PROD_W   = 2 * WEIGHT_W;
   localparam logic [WEIGHT_W-1:0] FRAC_ONE  = {1'b1, {F{1'b0}}};
   localparam logic [A-1:0]        PRIME_Y_A = PRIME_Y[A-1:0];
   localparam logic [A-1:0]        PRIME_Z_A = PRIME_Z[A-1:0];

   logic [RES_BITS-1:0] res_ff;

   logic [F-1:0]        coord_ff [3];
   logic [15:0]         ray_ff;
   logic [7:0]          batch_ff;
   logic [7:0]          point_ff;

   logic [SCALE_W-1:0]  scaled [3];
   logic [RES_BITS-1:0] cell_ff [3];
   logic [F-1:0]        frac_ff [3];

   logic [WEIGHT_W-1:0] wx [2];
   logic [WEIGHT_W-1:0] wy [2];
   logic [WEIGHT_W-1:0] wz [2];
   logic [PROD_W-1:0]   prod_xy [4];
   logic [RES_BITS-1:0] cyo [2];
   logic [RES_BITS-1:0] czo [2];
   logic [A-1:0]        hy_mul [2];
   logic [A-1:0]        hz_mul [2];
   logic [WEIGHT_W-1:0] wxy_ff [4];
   logic [WEIGHT_W-1:0] wz_ff [2];
   logic [A-1:0]        hy_ff [2];
   logic [A-1:0]        hz_ff [2];

   logic [RES_BITS-1:0] cxo;
   logic [A-1:0]        corner_addr;
   logic [PROD_W-1:0]   prod_w;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_ray_ff;
   logic [7:0]          rsp_batch_ff;
   logic [7:0]          rsp_point_ff;
   logic [CORNER_BITS-1:0] rsp_corner_ff;
   logic [A-1:0]        rsp_addr_ff;
   logic [WEIGHT_W-1:0] rsp_weight_ff;
   logic [DEST_BITS-1:0] rsp_dest_ff;
   logic                rsp_last_ff;
   logic [DEST_BITS-1:0] dest_ff, dest_in;

   // Resolution register
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= RES_RESET;
      end else if (csr_wr_en) begin
         res_ff <= csr_wr_data;
      end
   end

   // Point capture
   always_ff @(posedge clock) begin
      if (cmd.load_point) begin
         coord_ff[0] <= req_coord_x;
         coord_ff[1] <= req_coord_y;
         coord_ff[2] <= req_coord_z;
         ray_ff      <= req_ray_index;
         batch_ff    <= req_batch_index;
         point_ff    <= req_point_index;
      end
   end

   // Scale: one multiplier per axis, split into cell index and fraction
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         scaled[a] = SCALE_W'(coord_ff[a]) * SCALE_W'(res_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         for (int a = 0; a < 3; a++) begin
            cell_ff[a] <= scaled[a][SCALE_W-1:F];
            frac_ff[a] <= scaled[a][F-1:0];
         end
      end
   end

   // Prepare: per-axis weights, x*y weight products, y/z hash products
   always_comb begin
      wx[0] = FRAC_ONE - {1'b0, frac_ff[0]};
      wx[1] = {1'b0, frac_ff[0]};
      wy[0] = FRAC_ONE - {1'b0, frac_ff[1]};
      wy[1] = {1'b0, frac_ff[1]};
      wz[0] = FRAC_ONE - {1'b0, frac_ff[2]};
      wz[1] = {1'b0, frac_ff[2]};
      for (int i = 0; i < 4; i++) begin
         prod_xy[i] = PROD_W'(wx[i / 2]) * PROD_W'(wy[i % 2]);
      end
      // cell + 1 cannot overflow: the cell index stays below the resolution
      for (int i = 0; i < 2; i++) begin
         cyo[i]    = cell_ff[1] + RES_BITS'(i);
         czo[i]    = cell_ff[2] + RES_BITS'(i);
         hy_mul[i] = A'(cyo[i]) * PRIME_Y_A;
         hz_mul[i] = A'(czo[i]) * PRIME_Z_A;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         for (int i = 0; i < 4; i++) begin
            wxy_ff[i] <= prod_xy[i][PROD_W-2:F];
         end
         for (int i = 0; i < 2; i++) begin
            wz_ff[i] <= wz[i];
            hy_ff[i] <= hy_mul[i];
            hz_ff[i] <= hz_mul[i];
         end
      end
   end

   // Corner: hash select and final weight multiply
   always_comb begin
      cxo         = cell_ff[0] + RES_BITS'(cmd.corner[2]);
      corner_addr = A'(cxo) ^ hy_ff[cmd.corner[1]] ^ hz_ff[cmd.corner[0]];
      prod_w      = PROD_W'(wxy_ff[cmd.corner[2:1]]) * PROD_W'(wz_ff[cmd.corner[0]]);
   end

   // Output register
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      priority if (cmd.load_corner) rsp_valid_in = 1'b1;
      else if (rsp_ready)           rsp_valid_in = 1'b0;
      else                          rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_corner) begin
         rsp_ray_ff    <= ray_ff;
         rsp_batch_ff  <= batch_ff;
         rsp_point_ff  <= point_ff;
         rsp_corner_ff <= cmd.corner;
         rsp_addr_ff   <= corner_addr;
         rsp_weight_ff <= prod_w[PROD_W-2:F];
         rsp_dest_ff   <= dest_ff;
         rsp_last_ff   <= cmd.last_corner;
      end
   end

   // Destination slot counter, advances once the last corner is loaded
   assign dest_in = (cmd.load_corner && cmd.last_corner) ? dest_ff + DEST_BITS'(1) : dest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ff <= '0;
      end else begin
         dest_ff <= dest_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ray_tag       = rsp_ray_ff;
   assign rsp_batch_tag     = rsp_batch_ff;
   assign rsp_point_tag     = rsp_point_ff;
   assign rsp_corner_number = rsp_corner_ff;
   assign rsp_table_address = rsp_addr_ff;
   assign rsp_corner_weight = rsp_weight_ff;
   assign rsp_dest_slot     = rsp_dest_ff;
   assign rsp_last_corner   = rsp_last_ff;

endmodule

// ===== rtl/hash_grid_corner_request_gen_unit.sv =====
// Hash-grid corner request generator, top level.
// Each sample point becomes eight corner requests (hash address, trilinear
// weight, tags, destination slot) for a feature table.
//
// Channels: req_* takes one point per transfer (valid/ready); rsp_* gives
// eight requests per point, corners 0 to 7, with rsp_last_corner on corner 7.
// csr_wr_en/csr_wr_data write the grid resolution (cells per unit), to be
// written only while the block is idle.
// rsp_valid for the first corner rises once the point has passed the scale and
// prepare states and the output register is free. Each point is accepted,
// goes through the coordinate scale multipliers, then the weight and hash
// products, then sends its corners one by one through the single output register.
// req_ready is high only between points; the next point is taken while the
// last corner still waits in the output register.
// Receiver stall: the sequencer holds the current corner until the output
// register frees, so no request is lost or repeated.
// Reset: resolution returns to 16, the slot counter to 0, the output empties.
module hash_grid_corner_request_gen_unit
   import hgc_pkg::*;
#(
   parameter int TABLE_ADDR_BITS = 19,
   parameter int COORD_FRAC_BITS = 16,
   parameter int DEST_BITS       = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [RES_BITS-1:0]        csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [COORD_FRAC_BITS-1:0] req_coord_x,
   input  logic [COORD_FRAC_BITS-1:0] req_coord_y,
   input  logic [COORD_FRAC_BITS-1:0] req_coord_z,
   input  logic [15:0]                req_ray_index,
   input  logic [7:0]                 req_batch_index,
   input  logic [7:0]                 req_point_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [15:0]                rsp_ray_tag,
   output logic [7:0]                 rsp_batch_tag,
   output logic [7:0]                 rsp_point_tag,
   output logic [CORNER_BITS-1:0]     rsp_corner_number,
   output logic [TABLE_ADDR_BITS-1:0] rsp_table_address,
   output logic [COORD_FRAC_BITS:0]   rsp_corner_weight,
   output logic [DEST_BITS-1:0]       rsp_dest_slot,
   output logic                       rsp_last_corner
);

   hgc_cmd_type    cmd;
   hgc_status_type status;

   // Sequencer
   hgc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   hgc_datapath #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .DEST_BITS       (DEST_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_coord_z       (req_coord_z),
      .req_ray_index     (req_ray_index),
      .req_batch_index   (req_batch_index),
      .req_point_index   (req_point_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ray_tag       (rsp_ray_tag),
      .rsp_batch_tag     (rsp_batch_tag),
      .rsp_point_tag     (rsp_point_tag),
      .rsp_corner_number (rsp_corner_number),
      .rsp_table_address (rsp_table_address),
      .rsp_corner_weight (rsp_corner_weight),
      .rsp_dest_slot     (rsp_dest_slot),
      .rsp_last_corner   (rsp_last_corner)
   );

`ifndef NO_ASSERTIONS
   // A corner is loaded only when the output register can take it
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_corner |-> (!rsp_valid || rsp_ready))
      else $error("corner loaded over a pending request");

   // No corner is loaded while a new point may be accepted
   a_no_load_when_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !cmd.load_corner)
      else $error("corner loaded while idle");

   // After a point transfer the input stays closed while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input reopened right after a transfer");

   // Loading the final corner returns the sequencer to idle
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_corner && cmd.last_corner) |=> (req_ready && rsp_valid && rsp_last_corner))
      else $error("sequencer not idle after final corner");
`endif

endmodule
